@@ rtl/core/joystick_throttle_mapper_assert.svh @@
// ============================================================================
// Joystick throttle mapper assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ============================================================================
`ifndef JOYSTICK_THROTTLE_MAPPER_ASSERT_SVH
`define JOYSTICK_THROTTLE_MAPPER_ASSERT_SVH

`ifndef SYNTH

// General check, disabled while reset is asserted.
`define JTM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("joystick_throttle_mapper: assertion failed");

// Checks that a signal is low in the cycle after a reset cycle.
`define JTM_ASSERT_RESET(lbl, clk, rstn, sig) \
    lbl: assert property (@(posedge clk) !rstn |=> !sig) \
        else $error("joystick_throttle_mapper: signal not cleared by reset");

`else

`define JTM_ASSERT(lbl, clk, rstn, prop)
`define JTM_ASSERT_RESET(lbl, clk, rstn, sig)

`endif

`endif

@@ rtl/core/jtm_pkg.sv @@
// ============================================================================
// Joystick throttle mapper package
// Widths, register map, reset values, mode flag codes and shared types.
// ============================================================================
package jtm_pkg;

    // Field widths.
    localparam int STICK_W = 10;
    localparam int THR_W   = 12;
    localparam int TIME_W  = 32;
    localparam int SEQ_W   = 16;
    localparam int DB_W    = 8;
    localparam int HOLD_W  = 16;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Width of stick times throttle span.
    localparam int PROD_W  = STICK_W + THR_W;

    // Largest throttle value delivered.
    localparam logic [THR_W-1:0] THR_MAX = '1;

    // Register map, one 32-bit word per register.
    typedef enum logic [2:0] {
        REG_FAST_REV = 3'd0,
        REG_FAST_FWD = 3'd1,
        REG_SLOW_REV = 3'd2,
        REG_SLOW_FWD = 3'd3,
        REG_STOP     = 3'd4,
        REG_DEADBAND = 3'd5,
        REG_HOLD     = 3'd6
    } reg_idx_t;

    // Register reset values.
    localparam logic [THR_W-1:0]  RST_FAST_REV = 12'd1000;
    localparam logic [THR_W-1:0]  RST_FAST_FWD = 12'd2000;
    localparam logic [THR_W-1:0]  RST_SLOW_REV = 12'd1250;
    localparam logic [THR_W-1:0]  RST_SLOW_FWD = 12'd1750;
    localparam logic [THR_W-1:0]  RST_STOP     = 12'd1500;
    localparam logic [DB_W-1:0]   RST_DEADBAND = 8'd5;
    localparam logic [HOLD_W-1:0] RST_HOLD     = 16'd5000;

    // Mode change flag codes.
    typedef logic [1:0] flag_t;
    localparam flag_t CHG_NONE = 2'd0;
    localparam flag_t CHG_FAST = 2'd1;
    localparam flag_t CHG_SLOW = 2'd2;

    // Per-sample results of the mode tracker.
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        flag_t            flag;
        logic             fast;
    } mode_info_t;

endpackage

@@ rtl/core/jtm_mode.sv @@
// ============================================================================
// Joystick throttle mapper mode tracker
// Tracks the mode button, times the hold, toggles slow and fast mode and
// numbers the samples. State advances only on an accepted request.
// ============================================================================
module jtm_mode (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic                         button_pressed,
    input  logic [jtm_pkg::TIME_W-1:0]   now_ms,
    input  logic [jtm_pkg::HOLD_W-1:0]   hold_ms,
    output jtm_pkg::mode_info_t          info
);
    import jtm_pkg::*;

    logic              fast_reg, fast_next;
    logic [TIME_W-1:0] press_reg, press_next;
    logic              prev_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [TIME_W-1:0] press_start;
    logic [TIME_W-1:0] elapsed;
    logic              toggle;

    // A rising button edge restarts the hold timer at the sample time.
    assign press_start = (!prev_reg && button_pressed) ? now_ms : press_reg;
    assign elapsed     = now_ms - press_start;
    assign toggle      = button_pressed && (elapsed > {{(TIME_W-HOLD_W){1'b0}}, hold_ms});

    // Mode and timer updates after a completed hold.
    assign fast_next  = fast_reg ^ toggle;
    assign press_next = toggle ? now_ms : press_start;

    // Results for the sample being accepted.
    always_comb begin
        info.seq  = seq_reg;
        info.fast = fast_next;
        if (!toggle) begin
            info.flag = CHG_NONE;
        end else if (fast_next) begin
            info.flag = CHG_FAST;
        end else begin
            info.flag = CHG_SLOW;
        end
    end

    // State registers; the button reads as held out of reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_reg  <= 1'b0;
            press_reg <= '0;
            prev_reg  <= 1'b1;
            seq_reg   <= '0;
        end else if (accept) begin
            fast_reg  <= fast_next;
            press_reg <= press_next;
            prev_reg  <= button_pressed;
            seq_reg   <= seq_reg + 1'b1;
        end
    end

endmodule

@@ rtl/core/joystick_throttle_mapper.sv @@
// ============================================================================
// Joystick throttle mapper
// Maps joystick samples onto a throttle range chosen by a slow/fast mode
// button, applies a deadband around stop and numbers each result.
// ============================================================================
//
//  Channel   Ports                        Moves
//  --------  ---------------------------  ------------------------------------
//  sample    s_valid / s_ready / s_*      stick reading, button level, time
//  result    m_valid / m_ready / m_*      sequence, throttle, flag, mode
//  config    psel/penable/pwrite/paddr    APB register writes and reads
//
//  One request is accepted per cycle while s_ready is high; its result
//  reaches m_* through a five-register pipeline (input, span product,
//  reciprocal product, signed offset, deadband and clamp in the output
//  register). Each stage holds its request while the one after it is full,
//  so a stall on the result side fills the pipeline before s_ready falls.
//  Reset restores the register defaults, slow mode and sequence zero.
//
module joystick_throttle_mapper #(
    parameter int STICK_MAX = 1023
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [jtm_pkg::STICK_W-1:0]   s_stick_sample,
    input  logic                          s_button_pressed,
    input  logic [jtm_pkg::TIME_W-1:0]    s_now_ms,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [jtm_pkg::SEQ_W-1:0]     m_sequence_res,
    output logic [jtm_pkg::THR_W-1:0]     m_throttle,
    output logic [1:0]                    m_mode_flag,
    output logic                          m_fast_mode,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jtm_pkg::ADDR_W-1:0]    paddr,
    input  logic [jtm_pkg::DATA_W-1:0]    pwdata,
    output logic [jtm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import jtm_pkg::*;

    // Exact reciprocal of STICK_MAX for products below 2^PROD_W.
    localparam int          SHIFT   = PROD_W + $clog2(STICK_MAX);
    localparam int          RECIP_W = PROD_W + 1;
    localparam logic [63:0] RECIP   = ((64'd1 << SHIFT) + 64'(STICK_MAX) - 64'd1)
                                      / 64'(STICK_MAX);
    localparam int          FULL_W  = PROD_W + RECIP_W;
    localparam int          VAL_W   = PROD_W + 2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [THR_W-1:0]  fast_rev_reg, fast_fwd_reg, slow_rev_reg, slow_fwd_reg;
    logic [THR_W-1:0]  stop_reg;
    logic [DB_W-1:0]   db_reg;
    logic [HOLD_W-1:0] hold_reg;
    reg_idx_t          cfg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    // Register writes; the unused index is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_rev_reg <= RST_FAST_REV;
            fast_fwd_reg <= RST_FAST_FWD;
            slow_rev_reg <= RST_SLOW_REV;
            slow_fwd_reg <= RST_SLOW_FWD;
            stop_reg     <= RST_STOP;
            db_reg       <= RST_DEADBAND;
            hold_reg     <= RST_HOLD;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FAST_REV: fast_rev_reg <= pwdata[THR_W-1:0];
                REG_FAST_FWD: fast_fwd_reg <= pwdata[THR_W-1:0];
                REG_SLOW_REV: slow_rev_reg <= pwdata[THR_W-1:0];
                REG_SLOW_FWD: slow_fwd_reg <= pwdata[THR_W-1:0];
                REG_STOP:     stop_reg     <= pwdata[THR_W-1:0];
                REG_DEADBAND: db_reg       <= pwdata[DB_W-1:0];
                REG_HOLD:     hold_reg     <= pwdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (cfg_idx)
            REG_FAST_REV: prdata = {{(DATA_W-THR_W){1'b0}}, fast_rev_reg};
            REG_FAST_FWD: prdata = {{(DATA_W-THR_W){1'b0}}, fast_fwd_reg};
            REG_SLOW_REV: prdata = {{(DATA_W-THR_W){1'b0}}, slow_rev_reg};
            REG_SLOW_FWD: prdata = {{(DATA_W-THR_W){1'b0}}, slow_fwd_reg};
            REG_STOP:     prdata = {{(DATA_W-THR_W){1'b0}}, stop_reg};
            REG_DEADBAND: prdata = {{(DATA_W-DB_W){1'b0}}, db_reg};
            REG_HOLD:     prdata = {{(DATA_W-HOLD_W){1'b0}}, hold_reg};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or drains.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy_o;
    logic accept;

    assign rdy_o   = !m_valid_reg || m_ready;
    assign rdy4    = !v4_reg || rdy_o;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign accept  = s_valid && rdy1;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1)  v1_reg      <= s_valid;
            if (rdy2)  v2_reg      <= v1_reg;
            if (rdy3)  v3_reg      <= v2_reg;
            if (rdy4)  v4_reg      <= v3_reg;
            if (rdy_o) m_valid_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: mode tracking and input register
    // ------------------------------------------------------------------
    mode_info_t         info;
    mode_info_t         info1_reg, info2_reg, info3_reg, info4_reg;
    logic [STICK_W-1:0] stick1_reg;

    jtm_mode u_mode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .button_pressed (s_button_pressed),
        .now_ms         (s_now_ms),
        .hold_ms        (hold_reg),
        .info           (info)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            stick1_reg <= s_stick_sample;
            info1_reg  <= info;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: stick times the magnitude of the mode's span
    // ------------------------------------------------------------------
    logic [THR_W-1:0]  lo1, hi1, span_mag;
    logic [THR_W:0]    span;
    logic              span_neg;
    logic [PROD_W-1:0] pmag2_reg;
    logic              neg2_reg;

    assign lo1      = info1_reg.fast ? fast_rev_reg : slow_rev_reg;
    assign hi1      = info1_reg.fast ? fast_fwd_reg : slow_fwd_reg;
    assign span     = {1'b0, hi1} - {1'b0, lo1};
    assign span_neg = span[THR_W];
    assign span_mag = span_neg ? THR_W'(-span) : span[THR_W-1:0];

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            pmag2_reg <= PROD_W'(stick1_reg) * PROD_W'(span_mag);
            neg2_reg  <= span_neg;
            info2_reg <= info1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: quotient by STICK_MAX through the reciprocal
    // ------------------------------------------------------------------
    logic [RECIP_W-1:0] recip_c;
    logic [FULL_W-1:0]  full_prod;
    logic [FULL_W-1:0]  quot_full;
    logic [PROD_W-1:0]  q3_reg;
    logic               neg3_reg;

    assign recip_c   = RECIP[RECIP_W-1:0];
    assign full_prod = FULL_W'(pmag2_reg) * FULL_W'(recip_c);
    assign quot_full = full_prod >> SHIFT;

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            q3_reg    <= quot_full[PROD_W-1:0];
            neg3_reg  <= neg2_reg;
            info3_reg <= info2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: signed offset from the reverse value
    // ------------------------------------------------------------------
    logic [THR_W-1:0]        lo3;
    logic signed [VAL_W-1:0] q_s, val_sum;
    logic signed [VAL_W-1:0] val4_reg;

    assign lo3     = info3_reg.fast ? fast_rev_reg : slow_rev_reg;
    assign q_s     = signed'({2'b00, q3_reg});
    assign val_sum = signed'(VAL_W'(lo3)) + (neg3_reg ? -q_s : q_s);

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            val4_reg  <= val_sum;
            info4_reg <= info3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: deadband snap, then clamp to the throttle range
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] stop_s, db_s;
    logic                    in_band;
    logic [THR_W-1:0]        thr_next;
    logic [SEQ_W-1:0]        seq_o_reg;
    logic [THR_W-1:0]        thr_o_reg;
    flag_t                   flag_o_reg;
    logic                    fast_o_reg;

    assign stop_s  = signed'(VAL_W'(stop_reg));
    assign db_s    = signed'(VAL_W'(db_reg));
    assign in_band = (val4_reg < stop_s + db_s) && (val4_reg > stop_s - db_s);

    always_comb begin
        if (in_band) begin
            thr_next = stop_reg;
        end else if (val4_reg < 0) begin
            thr_next = '0;
        end else if (val4_reg > signed'(VAL_W'(THR_MAX))) begin
            thr_next = THR_MAX;
        end else begin
            thr_next = val4_reg[THR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_o && v4_reg) begin
            seq_o_reg  <= info4_reg.seq;
            thr_o_reg  <= thr_next;
            flag_o_reg <= info4_reg.flag;
            fast_o_reg <= info4_reg.fast;
        end
    end

    assign m_sequence_res = seq_o_reg;
    assign m_throttle     = thr_o_reg;
    assign m_mode_flag    = flag_o_reg;
    assign m_fast_mode    = fast_o_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "joystick_throttle_mapper_assert.svh"

    `JTM_ASSERT_RESET(a_rst_mvalid, aclk, aresetn, m_valid_reg)
    `JTM_ASSERT(a_to_fast, aclk, aresetn, m_valid_reg && m_mode_flag == CHG_FAST |-> m_fast_mode)
    `JTM_ASSERT(a_to_slow, aclk, aresetn, m_valid_reg && m_mode_flag == CHG_SLOW |-> !m_fast_mode)
    `JTM_ASSERT(a_flag_code, aclk, aresetn, m_valid_reg |-> m_mode_flag <= CHG_SLOW)
    `JTM_ASSERT(a_empty_ready, aclk, aresetn, !m_valid_reg |-> s_ready)
    `JTM_ASSERT(a_full, aclk, aresetn, v1_reg && v2_reg && v3_reg && v4_reg && !rdy_o |-> !s_ready)

endmodule
